FILE: design/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg: shared types and constants of the contiguous page allocator
// Page table geometry, status codes, sequencer states and the structs that
// travel between the register block, the sequencer and the page memory.
// ----------------------------------------------------------------------------
package cpa_pkg;

   localparam int NUM_ZONES  = 3;
   localparam int ZONE_PAGES = 1024;
   localparam int MAX_ORDER  = 10;

   localparam int PAGE_W    = 10;               // page index within a zone
   localparam int ZONE_W    = 2;                // zone number
   localparam int CNT_W     = 11;               // page counts up to ZONE_PAGES
   localparam int ORDER_W   = 4;
   localparam int ADDR_W    = ZONE_W + PAGE_W;  // {zone, page}
   localparam int MEM_DEPTH = NUM_ZONES * ZONE_PAGES;

   localparam logic [ORDER_W-1:0] NO_RUN = 4'd15;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [2:0] {
      STAT_OK          = 3'd0,
      STAT_ORDER_LARGE = 3'd1,
      STAT_NO_SPACE    = 3'd2,
      STAT_NOT_ALLOC   = 3'd3,
      STAT_MISMATCH    = 3'd4,
      STAT_COUNT_ERR   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ZSEL,
      S_SCAN,
      S_MARK,
      S_FCHK,
      S_FCLR,
      S_DONE
   } state_type;

   typedef logic [NUM_ZONES-1:0][CNT_W-1:0] zone_size_type;

   typedef struct packed {
      logic              valid;
      logic [ZONE_W-1:0] zone;
      logic [CNT_W-1:0]  size;   // already limited to ZONE_PAGES
   } cfg_write_type;

   typedef struct packed {
      logic               used;
      logic [ORDER_W-1:0] order;
   } page_entry_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      page_entry_type    wdata;
   } ram_req_type;

endpackage

FILE: design/cpa_page_ram.sv
// ----------------------------------------------------------------------------
// cpa_page_ram: page table memory
// One entry per page holds the used bit and the order recorded at the first
// page of a run. One port; read data is registered.
// ----------------------------------------------------------------------------
module cpa_page_ram (
   input  logic                  clock,
   input  cpa_pkg::ram_req_type  req,
   output cpa_pkg::page_entry_type rdata
);

   cpa_pkg::page_entry_type mem [0:cpa_pkg::MEM_DEPTH-1];
   cpa_pkg::page_entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.addr] <= req.wdata;
      end
      rdata_ff <= mem[req.addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/cpa_csr.sv
// ----------------------------------------------------------------------------
// cpa_csr: zone size registers
// Register port decode, readback and the effective (limited) zone sizes.
// ----------------------------------------------------------------------------
module cpa_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [3:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready,
   output cpa_pkg::cfg_write_type  cfg,
   output cpa_pkg::zone_size_type  zone_size
);

   logic [cpa_pkg::CNT_W-1:0] size_ff [cpa_pkg::NUM_ZONES];
   logic [cpa_pkg::CNT_W-1:0] size_in [cpa_pkg::NUM_ZONES];
   logic [1:0]                index;
   logic                      wr_en;
   logic [cpa_pkg::CNT_W-1:0] wval;
   logic [cpa_pkg::CNT_W-1:0] wval_lim;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign wval       = csr_pwdata[cpa_pkg::CNT_W-1:0];
   assign wval_lim   = (wval > cpa_pkg::CNT_W'(cpa_pkg::ZONE_PAGES))
                       ? cpa_pkg::CNT_W'(cpa_pkg::ZONE_PAGES) : wval;

   always_comb begin
      for (int z = 0; z < cpa_pkg::NUM_ZONES; z++) begin
         size_in[z] = size_ff[z];
         if (wr_en && (index == 2'(z))) begin
            size_in[z] = wval;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int z = 0; z < cpa_pkg::NUM_ZONES; z++) begin
            size_ff[z] <= (z == 0) ? cpa_pkg::CNT_W'(cpa_pkg::ZONE_PAGES) : '0;
         end
      end else begin
         for (int z = 0; z < cpa_pkg::NUM_ZONES; z++) begin
            size_ff[z] <= size_in[z];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      for (int z = 0; z < cpa_pkg::NUM_ZONES; z++) begin
         if (index == 2'(z)) begin
            csr_prdata = 32'(size_ff[z]);
         end
         zone_size[z] = (size_ff[z] > cpa_pkg::CNT_W'(cpa_pkg::ZONE_PAGES))
                        ? cpa_pkg::CNT_W'(cpa_pkg::ZONE_PAGES) : size_ff[z];
      end
   end

   assign cfg.valid = wr_en && (32'(index) < 32'(cpa_pkg::NUM_ZONES));
   assign cfg.zone  = index;
   assign cfg.size  = wval_lim;

endmodule

FILE: design/cpa_seq.sv
// ----------------------------------------------------------------------------
// cpa_seq: allocation sequencer
// Clears zones, scans for free runs, marks and releases runs in the page
// memory and keeps the free count of each zone.
// ----------------------------------------------------------------------------
module cpa_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  cpa_pkg::cfg_write_type         cfg,
   input  cpa_pkg::zone_size_type         zone_size,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic                           req_cmd,
   input  logic [cpa_pkg::ORDER_W-1:0]    req_order,
   input  logic [cpa_pkg::ZONE_W-1:0]     req_zone_sel,
   input  logic [cpa_pkg::PAGE_W-1:0]     req_page_index,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,
   output cpa_pkg::ram_req_type           ram_req,
   input  cpa_pkg::page_entry_type        ram_rdata
);

   localparam int CW = cpa_pkg::CNT_W;
   localparam int PW = cpa_pkg::PAGE_W;
   localparam int ZW = cpa_pkg::ZONE_W;

   cpa_pkg::state_type  state_ff, state_in;
   logic [cpa_pkg::NUM_ZONES-1:0] pend_ff, pend_in;
   logic [PW-1:0]       clr_pg_ff, clr_pg_in;
   logic [cpa_pkg::ORDER_W-1:0] order_ff, order_in;
   logic [ZW-1:0]       zs_ff, zs_in;
   logic [PW-1:0]       pg_ff, pg_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [ZW-1:0]       zone_ff, zone_in;
   logic [CW-1:0]       rd_pg_ff, rd_pg_in;
   logic [CW-1:0]       rd_cnt_ff, rd_cnt_in;
   logic                ev_valid_ff, ev_valid_in;
   logic [CW-1:0]       ev_pg_ff, ev_pg_in;
   logic                ev_first_ff, ev_first_in;
   logic                ev_last_ff, ev_last_in;
   logic [CW-1:0]       run_ff, run_in;
   logic [CW-1:0]       wr_cnt_ff, wr_cnt_in;
   logic [PW-1:0]       first_ff, first_in;
   logic [CW-1:0]       free_ff [cpa_pkg::NUM_ZONES];
   logic [CW-1:0]       free_in [cpa_pkg::NUM_ZONES];
   cpa_pkg::status_type res_status_ff, res_status_in;
   logic [ZW-1:0]       res_zone_ff, res_zone_in;
   logic [PW-1:0]       res_page_ff, res_page_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_data_ff, rsp_data_in;

   logic [CW-1:0]       size_zone, size_zs, size_req, free_zone;
   logic [ZW-1:0]       clr_zone;
   logic [CW-1:0]       run_next, found_first, pg_end;

   // Per-zone lookups by a signal-chosen zone number.
   always_comb begin
      size_zone = '0;
      size_zs   = '0;
      size_req  = '0;
      free_zone = '0;
      clr_zone  = '0;
      for (int z = cpa_pkg::NUM_ZONES - 1; z >= 0; z--) begin
         if (zone_ff == ZW'(z)) begin
            size_zone = zone_size[z];
            free_zone = free_ff[z];
         end
         if (zs_ff == ZW'(z)) begin
            size_zs = zone_size[z];
         end
         if (req_zone_sel == ZW'(z)) begin
            size_req = zone_size[z];
         end
         if (pend_ff[z]) begin
            clr_zone = ZW'(z);
         end
      end
   end

   assign run_next    = ram_rdata.used ? '0 : run_ff + 1'b1;
   assign found_first = ev_pg_ff - count_ff + 1'b1;
   assign pg_end      = CW'(pg_ff) + count_ff;

   assign req_tready = (state_ff == cpa_pkg::S_IDLE) && (pend_ff == '0);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      pend_in       = pend_ff;
      clr_pg_in     = clr_pg_ff;
      order_in      = order_ff;
      zs_in         = zs_ff;
      pg_in         = pg_ff;
      count_in      = count_ff;
      zone_in       = zone_ff;
      rd_pg_in      = rd_pg_ff;
      rd_cnt_in     = rd_cnt_ff;
      ev_valid_in   = 1'b0;
      ev_pg_in      = ev_pg_ff;
      ev_first_in   = ev_first_ff;
      ev_last_in    = ev_last_ff;
      run_in        = run_ff;
      wr_cnt_in     = wr_cnt_ff;
      first_in      = first_ff;
      res_status_in = res_status_ff;
      res_zone_in   = res_zone_ff;
      res_page_in   = res_page_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      for (int z = 0; z < cpa_pkg::NUM_ZONES; z++) begin
         free_in[z] = free_ff[z];
      end
      ram_req.we    = 1'b0;
      ram_req.addr  = {zone_ff, rd_pg_ff[PW-1:0]};
      ram_req.wdata = '{used: 1'b0, order: cpa_pkg::NO_RUN};

      unique case (state_ff)
         cpa_pkg::S_CLEAR: begin
            ram_req.we   = 1'b1;
            ram_req.addr = {clr_zone, clr_pg_ff};
            clr_pg_in    = clr_pg_ff + 1'b1;
            if (clr_pg_ff == PW'(cpa_pkg::ZONE_PAGES - 1)) begin
               for (int z = 0; z < cpa_pkg::NUM_ZONES; z++) begin
                  if (clr_zone == ZW'(z)) begin
                     pend_in[z] = 1'b0;
                  end
               end
               if ((pend_in == '0) && !cfg.valid) begin
                  state_in = cpa_pkg::S_IDLE;
               end
            end
         end
         cpa_pkg::S_IDLE: begin
            if (pend_ff != '0) begin
               state_in  = cpa_pkg::S_CLEAR;
               clr_pg_in = '0;
            end else if (req_tvalid) begin
               order_in    = req_order;
               zs_in       = req_zone_sel;
               pg_in       = req_page_index;
               count_in    = CW'(1) << req_order;
               zone_in     = '0;
               rd_pg_in    = CW'(req_page_index);
               rd_cnt_in   = '0;
               run_in      = '0;
               res_zone_in = '0;
               res_page_in = '0;
               if (32'(req_order) > cpa_pkg::MAX_ORDER) begin
                  res_status_in = cpa_pkg::STAT_ORDER_LARGE;
                  state_in      = cpa_pkg::S_DONE;
               end else if (req_cmd == cpa_pkg::CMD_ALLOC) begin
                  state_in = cpa_pkg::S_ZSEL;
               end else if ((32'(req_zone_sel) >= cpa_pkg::NUM_ZONES)
                            || (CW'(req_page_index) >= size_req)) begin
                  res_status_in = cpa_pkg::STAT_NOT_ALLOC;
                  state_in      = cpa_pkg::S_DONE;
               end else begin
                  state_in = cpa_pkg::S_FCHK;
               end
            end
         end
         cpa_pkg::S_ZSEL: begin
            rd_pg_in = '0;
            run_in   = '0;
            if (32'(zone_ff) >= cpa_pkg::NUM_ZONES) begin
               res_status_in = cpa_pkg::STAT_NO_SPACE;
               state_in      = cpa_pkg::S_DONE;
            end else if (free_zone > count_ff) begin
               state_in = cpa_pkg::S_SCAN;
            end else begin
               zone_in = zone_ff + 1'b1;
            end
         end
         cpa_pkg::S_SCAN: begin
            // Reads stream one page a cycle; the run length is judged in the next
            // cycle, when the entry arrives.
            if (rd_pg_ff < size_zone) begin
               rd_pg_in    = rd_pg_ff + 1'b1;
               ev_valid_in = 1'b1;
               ev_pg_in    = rd_pg_ff;
            end
            if (ev_valid_ff) begin
               run_in = run_next;
               if (run_next == count_ff) begin
                  first_in    = found_first[PW-1:0];
                  wr_cnt_in   = '0;
                  ev_valid_in = 1'b0;
                  state_in    = cpa_pkg::S_MARK;
               end
            end else if (rd_pg_ff >= size_zone) begin
               zone_in  = zone_ff + 1'b1;
               state_in = cpa_pkg::S_ZSEL;
            end
         end
         cpa_pkg::S_MARK: begin
            ram_req.we         = 1'b1;
            ram_req.addr       = {zone_ff, first_ff + wr_cnt_ff[PW-1:0]};
            ram_req.wdata.used = 1'b1;
            ram_req.wdata.order = (wr_cnt_ff == '0) ? order_ff : cpa_pkg::NO_RUN;
            wr_cnt_in          = wr_cnt_ff + 1'b1;
            if (wr_cnt_ff == count_ff - 1'b1) begin
               for (int z = 0; z < cpa_pkg::NUM_ZONES; z++) begin
                  if (zone_ff == ZW'(z)) begin
                     free_in[z] = free_ff[z] - count_ff;
                  end
               end
               res_status_in = cpa_pkg::STAT_OK;
               res_zone_in   = zone_ff;
               res_page_in   = first_ff;
               state_in      = cpa_pkg::S_DONE;
            end
         end
         cpa_pkg::S_FCHK: begin
            ram_req.addr = {zs_ff, rd_pg_ff[PW-1:0]};
            if (rd_cnt_ff < count_ff) begin
               rd_pg_in    = rd_pg_ff + 1'b1;
               rd_cnt_in   = rd_cnt_ff + 1'b1;
               ev_valid_in = 1'b1;
               ev_first_in = (rd_cnt_ff == '0);
               ev_last_in  = (rd_cnt_ff == count_ff - 1'b1);
            end
            if (ev_valid_ff) begin
               if (ev_first_ff && !ram_rdata.used) begin
                  res_status_in = cpa_pkg::STAT_NOT_ALLOC;
                  state_in      = cpa_pkg::S_DONE;
               end else if (ev_first_ff && (ram_rdata.order != order_ff)) begin
                  res_status_in = cpa_pkg::STAT_MISMATCH;
                  state_in      = cpa_pkg::S_DONE;
               end else if ((ev_first_ff && (pg_end > size_zs))
                            || !ram_rdata.used) begin
                  res_status_in = cpa_pkg::STAT_COUNT_ERR;
                  state_in      = cpa_pkg::S_DONE;
               end else if (ev_last_ff) begin
                  wr_cnt_in = '0;
                  state_in  = cpa_pkg::S_FCLR;
               end
               if (state_in != cpa_pkg::S_FCHK) begin
                  ev_valid_in = 1'b0;
               end
            end
         end
         cpa_pkg::S_FCLR: begin
            ram_req.we   = 1'b1;
            ram_req.addr = {zs_ff, pg_ff + wr_cnt_ff[PW-1:0]};
            wr_cnt_in    = wr_cnt_ff + 1'b1;
            if (wr_cnt_ff == count_ff - 1'b1) begin
               for (int z = 0; z < cpa_pkg::NUM_ZONES; z++) begin
                  if (zs_ff == ZW'(z)) begin
                     free_in[z] = free_ff[z] + count_ff;
                  end
               end
               res_status_in = cpa_pkg::STAT_OK;
               state_in      = cpa_pkg::S_DONE;
            end
         end
         cpa_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, res_page_ff, res_zone_ff, res_status_ff};
               state_in     = cpa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cpa_pkg::S_IDLE;
         end
      endcase

      // A size write empties the zone: its count is refilled at once and the
      // page entries are swept before the next request is taken.
      if (cfg.valid) begin
         for (int z = 0; z < cpa_pkg::NUM_ZONES; z++) begin
            if (cfg.zone == ZW'(z)) begin
               free_in[z] = cfg.size;
               pend_in[z] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpa_pkg::S_CLEAR;
         pend_ff      <= '1;
         clr_pg_ff    <= '0;
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int z = 0; z < cpa_pkg::NUM_ZONES; z++) begin
            free_ff[z] <= (z == 0) ? CW'(cpa_pkg::ZONE_PAGES) : '0;
         end
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         clr_pg_ff    <= clr_pg_in;
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int z = 0; z < cpa_pkg::NUM_ZONES; z++) begin
            free_ff[z] <= free_in[z];
         end
      end
   end

   always_ff @(posedge clock) begin
      order_ff      <= order_in;
      zs_ff         <= zs_in;
      pg_ff         <= pg_in;
      count_ff      <= count_in;
      zone_ff       <= zone_in;
      rd_pg_ff      <= rd_pg_in;
      rd_cnt_ff     <= rd_cnt_in;
      ev_pg_ff      <= ev_pg_in;
      ev_first_ff   <= ev_first_in;
      ev_last_ff    <= ev_last_in;
      run_ff        <= run_in;
      wr_cnt_ff     <= wr_cnt_in;
      first_ff      <= first_in;
      res_status_ff <= res_status_in;
      res_zone_ff   <= res_zone_in;
      res_page_ff   <= res_page_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

FILE: design/contiguous_page_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_page_allocator: first-fit allocator of 2^order page runs
// Three zones of up to 1024 pages. Allocate takes the first zone whose free
// count exceeds the run length and scans it for the first free run, moving
// on if none is found; free checks and releases a previously allocated run.
// ----------------------------------------------------------------------------
//
//  Port group | Direction | Carries
//  req_*      | in        | request: tuser = cmd, tdata = order, zone, page
//  rsp_*      | out       | result: tdata = status, zone, first page
//  csr_*      | in/out    | zone size registers at byte addresses 0, 4, 8
//
// After reset the page table is swept clean before the first request is
// taken. A size write sweeps that zone. An allocate passes over each zone
// whose free count does not exceed the run length, scans the other zones
// page by page for a free run, marks the run it finds and posts the result.
// A free checks the run page by page and then releases it. The page table
// memory has a single port, which handles one page per cycle. One request
// is worked on at a time.
// The result sits in an output register; a stalled rsp_tready holds it and
// the block can take the next request meanwhile.
// ----------------------------------------------------------------------------
module contiguous_page_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [3:0] order, [5:4] zone_sel, [15:6] page_index
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] status, [4:3] zone_out, [14:5] page_out
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cpa_pkg::cfg_write_type   cfg;
   cpa_pkg::zone_size_type   zone_size;
   cpa_pkg::ram_req_type     ram_req;
   cpa_pkg::page_entry_type  ram_rdata;

   // Zone size registers and their readback.
   cpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .zone_size   (zone_size)
   );

   // Sequencer: clearing sweep, run search, marking and release.
   cpa_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .zone_size      (zone_size),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_cmd        (req_tuser),
      .req_order      (req_tdata[3:0]),
      .req_zone_sel   (req_tdata[5:4]),
      .req_page_index (req_tdata[15:6]),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .ram_req        (ram_req),
      .ram_rdata      (ram_rdata)
   );

   // Page table: used bit and recorded order for every page of every zone.
   cpa_page_ram u_ram (
      .clock (clock),
      .req   (ram_req),
      .rdata (ram_rdata)
   );

endmodule

FILE: design/cpa_checker.sv
// ----------------------------------------------------------------------------
// cpa_checker: port-level checks of the page allocator
// Watches the request, result and register ports over time.
// ----------------------------------------------------------------------------
module cpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        csr_pready
);

   // A held result keeps its value until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Only successful requests report a zone or page.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] != 3'd0) |-> (rsp_tdata[15:3] == 13'd0))
      else $error("error result carries zone or page");

   // Status codes stay within the defined set.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= 3'd5))
      else $error("undefined status code");

   // One request at a time: busy right after an acceptance.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // Reset leaves no result pending and the table sweep blocks requests.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready && csr_pready)
      else $error("bad state after reset");

endmodule

bind contiguous_page_allocator cpa_checker u_cpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
